// ===== rtl/core/kl_pkg.sv =====
// keyword lexer package: keyword table, character and token codes, shared types
package kl_pkg;

    localparam int TABLE_SIZE = 34;
    localparam int KW_MAX_LEN = 10;

    typedef logic [7:0] char_t;
    typedef logic [5:0] code_t;
    typedef logic [3:0] len_t;

    localparam code_t STRING_CODE  = 6'd34;
    localparam code_t UNKNOWN_CODE = 6'd35;
    localparam len_t  LENGTH_MAX   = 4'd15;

    localparam char_t CH_NUL    = 8'h00;
    localparam char_t CH_TAB    = 8'h09;
    localparam char_t CH_LF     = 8'h0A;
    localparam char_t CH_SPACE  = 8'h20;
    localparam char_t CH_COMMA  = 8'h2C;
    localparam char_t CH_COLON  = 8'h3A;
    localparam char_t CH_LBRACE = 8'h7B;
    localparam char_t CH_RBRACE = 8'h7D;

    // table positions of the single-character delimiter and space entries
    localparam code_t CODE_LBRACE = 6'd28;
    localparam code_t CODE_RBRACE = 6'd29;
    localparam code_t CODE_COMMA  = 6'd30;
    localparam code_t CODE_COLON  = 6'd31;
    localparam code_t CODE_SPACE  = 6'd33;

    // one queued byte outcome: one or two tokens
    typedef struct packed {
        logic  two;
        code_t first;
        code_t last;
    } result_t;

    // keyword text, right-justified: last character in bits 7:0
    localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [TABLE_SIZE] = '{
        "IF", "ALL", "IN", "FOR", "FROM", "PREPARE", "REQUEST", "ANALYZE",
        "SEND", "CONTENT", "TYPE", "LENGTH", "TO", "SCHEME", "STATUS", "CODE",
        "HEADERS", "METHOD", "AVAILABLE", "BODY", "CONNECTION", "LANGUAGES",
        {"USER_", "AGENT"}, "HOST", "HTTP", "HTTPS", "EXTRACT", "->", "{", "}", ",",
        ":", "\"", " "
    };

    localparam len_t KW_LEN [TABLE_SIZE] = '{
        4'd2, 4'd3, 4'd2, 4'd3, 4'd4, 4'd7, 4'd7, 4'd7, 4'd4, 4'd7, 4'd4,
        4'd6, 4'd2, 4'd6, 4'd6, 4'd4, 4'd7, 4'd6, 4'd9, 4'd4, 4'd10, 4'd9,
        4'd10, 4'd4, 4'd4, 4'd5, 4'd7, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1
    };

    // true when keyword idx has character c at position pos
    function automatic logic kw_char_match(int idx, len_t pos, char_t c);
        logic [KW_MAX_LEN*8-1:0] txt;
        int sh;
        txt = KW_TEXT[idx];
        if (pos >= KW_LEN[idx])
        begin
            return 1'b0;
        end
        sh = 8 * (int'(KW_LEN[idx]) - 1 - int'(pos));
        return txt[sh +: 8] == c;
    endfunction

endpackage

// ===== rtl/core/kl_if.sv =====
// keyword lexer stream channels: text bytes in, token words out
interface kl_byte_if;
    import kl_pkg::*;
    logic  valid;
    logic  ready;
    char_t text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface kl_token_if;
    import kl_pkg::*;
    logic  valid;
    logic  ready;
    code_t tok_code;
    logic  last_of_run;

    modport source (output valid, output tok_code, output last_of_run, input ready);
    modport sink   (input valid, input tok_code, input last_of_run, output ready);
endinterface

// ===== rtl/core/keyword_lexer_top.sv =====
// Keyword lexer: one text byte per word in, keyword or STRING tokens out.
// A byte is taken every cycle while the two-entry result queue has room. A byte
// that yields no token or one token fills at most one queue entry; a byte that ends
// a word at a delimiter or space yields two tokens in one entry, and the single
// output port sends them as two words, so input can be held off while such an
// entry drains. The candidate mask and word length are updated in the accept
// cycle; there is no clearing pass after reset.
module keyword_lexer_top
    import kl_pkg::*;
#(
    parameter int KEYWORD_COUNT = 34
)
(
    input logic          clk,
    input logic          rst_n,
    kl_byte_if.sink      text,
    kl_token_if.source   tokens
);

    localparam int ACTIVE_COUNT = (KEYWORD_COUNT < TABLE_SIZE) ? KEYWORD_COUNT : TABLE_SIZE;
    localparam logic [ACTIVE_COUNT-1:0] MASK_ALL = '1;

    logic [ACTIVE_COUNT-1:0] mask_reg, mask_next;
    len_t                    len_reg, len_next;
    result_t                 q_reg [2];
    logic                    wr_ptr_reg, wr_ptr_next;
    logic                    rd_ptr_reg, rd_ptr_next;
    logic [1:0]              cnt_reg, cnt_next;
    logic                    sub_reg, sub_next;

    char_t   c;
    logic    delim;
    logic    sep;
    logic    accept;
    logic    push;
    logic    pop;
    code_t   word_code;
    code_t   delim_idx;
    code_t   delim_code;
    result_t res;
    result_t head;
    logic    head_first;

    assign c      = text.text_byte;
    assign delim  = (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_COLON) || (c == CH_COMMA);
    assign sep    = delim || (c == CH_NUL) || (c == CH_SPACE) || (c == CH_LF) || (c == CH_TAB);
    assign text.ready = (cnt_reg != 2'd2);
    assign accept = text.valid && text.ready;

    // lowest surviving keyword of the same length as the pending word
    always_comb
    begin
        word_code = STRING_CODE;
        for (int i = ACTIVE_COUNT - 1; i >= 0; i--)
        begin
            if (mask_reg[i] && (KW_LEN[i] == len_reg))
            begin
                word_code = code_t'(i);
            end
        end
    end

    always_comb
    begin
        case (c)
            CH_LBRACE: delim_idx = CODE_LBRACE;
            CH_RBRACE: delim_idx = CODE_RBRACE;
            CH_COMMA:  delim_idx = CODE_COMMA;
            CH_COLON:  delim_idx = CODE_COLON;
            default:   delim_idx = CODE_SPACE;
        endcase
        delim_code = (int'(delim_idx) < ACTIVE_COUNT) ? delim_idx : UNKNOWN_CODE;
    end

    always_comb
    begin
        res.two   = 1'b0;
        res.first = word_code;
        res.last  = delim_code;
        if (len_reg != 4'd0)
        begin
            res.two = delim || (c == CH_SPACE);
            if (!res.two)
            begin
                res.last = word_code;
            end
        end
    end

    assign push = accept && sep && ((len_reg != 4'd0) || delim);

    always_comb
    begin
        mask_next = mask_reg;
        len_next  = len_reg;
        if (accept)
        begin
            if (sep)
            begin
                mask_next = MASK_ALL;
                len_next  = 4'd0;
            end
            else
            begin
                for (int i = 0; i < ACTIVE_COUNT; i++)
                begin
                    if (!kw_char_match(i, len_reg, c))
                    begin
                        mask_next[i] = 1'b0;
                    end
                end
                if (len_reg < LENGTH_MAX)
                begin
                    len_next = len_reg + 4'd1;
                end
            end
        end
    end

    // output side: a two-token entry is sent as two words
    assign head       = q_reg[rd_ptr_reg];
    assign head_first = head.two && !sub_reg;
    assign tokens.valid       = (cnt_reg != 2'd0);
    assign tokens.tok_code    = head_first ? head.first : head.last;
    assign tokens.last_of_run = !head_first;
    assign pop = tokens.valid && tokens.ready && !head_first;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
        sub_next    = sub_reg;
        if (tokens.valid && tokens.ready)
        begin
            sub_next = head_first;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg   <= MASK_ALL;
            len_reg    <= 4'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
            sub_reg    <= 1'b0;
        end
        else
        begin
            mask_reg   <= mask_next;
            len_reg    <= len_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            sub_reg    <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= res;
        end
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result queue overflow");

    a_empty_word_full_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg == 4'd0) |-> (mask_reg == MASK_ALL))
        else $error("mask not full with no pending word");

    a_sep_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && sep) |=> (len_reg == 4'd0))
        else $error("separator did not clear the word");

    a_len_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !sep && (len_reg != LENGTH_MAX)) |=> (len_reg == $past(len_reg) + 4'd1))
        else $error("word length did not advance");

    a_sub_only_two: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg |-> (tokens.valid && head.two))
        else $error("second-token phase without a two-token entry");
`endif

endmodule
